FILE: rtl/ptcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcf_pkg: shared types and constants of the pixel text command formatter
// Line layout, ASCII codes, register indexes and digit helpers.
// ----------------------------------------------------------------------------
package ptcf_pkg;

	localparam int LINE_BYTES = 20;
	localparam int CNT_W      = 5;   // holds 0..LINE_BYTES
	localparam int COORD_W    = 12;  // width of col, row and offset fields
	localparam int DEC_W      = 14;  // working width of the decimal split
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef logic [7:0] char_t;
	typedef char_t [LINE_BYTES-1:0] line_t;   // element 0 goes out first

	typedef enum logic [REG_IDX_W-1:0] {
		REG_X_OFFSET = 2'd0,
		REG_Y_OFFSET = 2'd1
	} reg_idx_t;

	localparam char_t CH_P     = 8'h50;
	localparam char_t CH_X     = 8'h58;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_LOW_A = 8'h61;

	// Decimal digit (0..9) of v for the given unit, v < 10*unit assumed.
	// Nine independent compares, largest hit wins.
	function automatic logic [3:0] digit_of(input logic [DEC_W-1:0] v, input int unit);
		logic [3:0] d;
		d = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= DEC_W'(k * unit)) d = 4'(k);
		end
		return d;
	endfunction

	function automatic char_t dec_char(input logic [3:0] d);
		return CH_ZERO + {4'b0, d};
	endfunction

	function automatic char_t hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_ZERO + {4'b0, n};
		else return CH_LOW_A + {4'b0, n} - 8'd10;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ptcf_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcf_serializer: line to byte stream
// Loads a whole 20-byte command line and shifts it out one byte per
// transaction; takes the next line in the cycle the newline leaves.
// ----------------------------------------------------------------------------
module ptcf_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load_valid,
	output logic                 load_ready,
	input  wire ptcf_pkg::line_t load_line,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast
);

	ptcf_pkg::line_t                 shift_q;
	logic [ptcf_pkg::CNT_W-1:0]      cnt_q;   // bytes still to send
	logic                            byte_done;

	assign byte_done  = m_tvalid && m_tready;
	assign load_ready = (cnt_q == '0) || ((cnt_q == ptcf_pkg::CNT_W'(1)) && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_valid && load_ready) begin
			cnt_q <= ptcf_pkg::CNT_W'(ptcf_pkg::LINE_BYTES);
		end else if (byte_done) begin
			cnt_q <= cnt_q - ptcf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			shift_q <= load_line;
		end else if (byte_done) begin
			shift_q <= ptcf_pkg::line_t'(shift_q >> 8);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = shift_q[0];
	assign m_tlast  = (cnt_q == ptcf_pkg::CNT_W'(1));

endmodule
`default_nettype wire

FILE: rtl/pixel_text_command_formatter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_text_command_formatter_unit: pixel to "PX" text command encoder
// Turns each pixel into the ASCII line "PX XXXX YYYY rrggbb\n".
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream (s_*): one transaction per pixel, tdata = col, row, red,
//    green, blue from bit 0 up (48 bits).
//  - Master stream (m_*): one transaction per byte of the command line,
//    20 per pixel; tlast marks the closing newline.
//  - Config channel (cfg_*): index 0 = x offset, 1 = y offset, always ready;
//    other indexes are dropped. Write only while the block is idle.
//  - Coordinates are col + x offset and row + y offset, printed as four
//    zero-padded decimal digits; colour as six lowercase hex digits.
//  - Path: a pixel passes stage 1, stage 2, stage 3 and the serializer's
//    line register before m_tvalid rises, when the output side is empty.
//  - The pixel rate is set by the byte-wide output port.
//    Three pixels can queue in the conversion stages behind a line that
//    is still being sent, so input is taken while output drains.
//  - Reset clears all valid flags and both offsets to 0.
//  - A stalled receiver holds the current byte; the stages fill up and
//    s_tready drops once all of them hold a pixel.
// ----------------------------------------------------------------------------
module pixel_text_command_formatter_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,     // col[11:0], row[11:0], red, green, blue
	// text out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,     // out_char[7:0]
	output logic             m_tlast,     // last
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [ptcf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [ptcf_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Effective coordinate width; fields are 12 bits, so at most 12 count.
	// The sum then stays at or below 8190 and always fits four digits.
	localparam int CW = (COORD_BITS < ptcf_pkg::COORD_W) ? COORD_BITS : ptcf_pkg::COORD_W;
	localparam int DW = ptcf_pkg::DEC_W;

	// ---------------- configuration ----------------
	logic [ptcf_pkg::COORD_W-1:0] x_off_q, y_off_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= '0;
			y_off_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptcf_pkg::REG_X_OFFSET: x_off_q <= cfg_data;
				ptcf_pkg::REG_Y_OFFSET: y_off_q <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// ---------------- stage control ----------------
	logic v_s1, v_s2, v_s3;
	logic free_s1, free_s2, free_s3;
	logic ld_ready;

	assign free_s3  = !v_s3 || ld_ready;
	assign free_s2  = !v_s2 || free_s3;
	assign free_s1  = !v_s1 || free_s2;
	assign s_tready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free_s1) v_s1 <= s_tvalid;
			if (free_s2) v_s2 <= v_s1;
			if (free_s3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic [ptcf_pkg::COORD_W-1:0] col_s1, row_s1;
	logic [23:0]                  rgb_s1;   // red, green, blue from bit 0 up

	always_ff @(posedge clk) begin
		if (free_s1 && s_tvalid) begin
			col_s1 <= s_tdata[11:0];
			row_s1 <= s_tdata[23:12];
			rgb_s1 <= s_tdata[47:24];
		end
	end

	// ---------------- stage 2: offset add, thousands digit ----------------
	logic [DW-1:0] x_sum, y_sum;
	logic [3:0]    x_th, y_th;
	logic [DW-1:0] x_r1, y_r1;

	always_comb begin
		x_sum = DW'(col_s1[CW-1:0]) + DW'(x_off_q[CW-1:0]);
		y_sum = DW'(row_s1[CW-1:0]) + DW'(y_off_q[CW-1:0]);
		x_th  = ptcf_pkg::digit_of(x_sum, 1000);
		y_th  = ptcf_pkg::digit_of(y_sum, 1000);
		x_r1  = x_sum - DW'(x_th * 1000);
		y_r1  = y_sum - DW'(y_th * 1000);
	end

	logic [3:0]  x_th_s2, y_th_s2;
	logic [9:0]  x_r_s2, y_r_s2;   // below 1000
	logic [23:0] rgb_s2;

	always_ff @(posedge clk) begin
		if (free_s2 && v_s1) begin
			x_th_s2 <= x_th;
			y_th_s2 <= y_th;
			x_r_s2  <= x_r1[9:0];
			y_r_s2  <= y_r1[9:0];
			rgb_s2  <= rgb_s1;
		end
	end

	// ---------------- stage 3: hundreds, tens, ones ----------------
	logic [3:0]    x_hu, y_hu, x_te, y_te;
	logic [DW-1:0] x_r2, y_r2, x_r3, y_r3;

	always_comb begin
		x_hu = ptcf_pkg::digit_of(DW'(x_r_s2), 100);
		y_hu = ptcf_pkg::digit_of(DW'(y_r_s2), 100);
		x_r2 = DW'(x_r_s2) - DW'(x_hu * 100);
		y_r2 = DW'(y_r_s2) - DW'(y_hu * 100);
		x_te = ptcf_pkg::digit_of(x_r2, 10);
		y_te = ptcf_pkg::digit_of(y_r2, 10);
		x_r3 = x_r2 - DW'(x_te * 10);
		y_r3 = y_r2 - DW'(y_te * 10);
	end

	logic [15:0] x_dig_s3, y_dig_s3;   // thousands in the top nibble
	logic [23:0] rgb_s3;

	always_ff @(posedge clk) begin
		if (free_s3 && v_s2) begin
			x_dig_s3 <= {x_th_s2, x_hu, x_te, x_r3[3:0]};
			y_dig_s3 <= {y_th_s2, y_hu, y_te, y_r3[3:0]};
			rgb_s3   <= rgb_s2;
		end
	end

	// ---------------- line assembly ----------------
	ptcf_pkg::line_t line;

	always_comb begin
		line[0]  = ptcf_pkg::CH_P;
		line[1]  = ptcf_pkg::CH_X;
		line[2]  = ptcf_pkg::CH_SPACE;
		line[3]  = ptcf_pkg::dec_char(x_dig_s3[15:12]);
		line[4]  = ptcf_pkg::dec_char(x_dig_s3[11:8]);
		line[5]  = ptcf_pkg::dec_char(x_dig_s3[7:4]);
		line[6]  = ptcf_pkg::dec_char(x_dig_s3[3:0]);
		line[7]  = ptcf_pkg::CH_SPACE;
		line[8]  = ptcf_pkg::dec_char(y_dig_s3[15:12]);
		line[9]  = ptcf_pkg::dec_char(y_dig_s3[11:8]);
		line[10] = ptcf_pkg::dec_char(y_dig_s3[7:4]);
		line[11] = ptcf_pkg::dec_char(y_dig_s3[3:0]);
		line[12] = ptcf_pkg::CH_SPACE;
		line[13] = ptcf_pkg::hex_char(rgb_s3[7:4]);
		line[14] = ptcf_pkg::hex_char(rgb_s3[3:0]);
		line[15] = ptcf_pkg::hex_char(rgb_s3[15:12]);
		line[16] = ptcf_pkg::hex_char(rgb_s3[11:8]);
		line[17] = ptcf_pkg::hex_char(rgb_s3[23:20]);
		line[18] = ptcf_pkg::hex_char(rgb_s3[19:16]);
		line[19] = ptcf_pkg::CH_NL;
	end

	// ---------------- byte output ----------------
	ptcf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (v_s3),
		.load_ready (ld_ready),
		.load_line  (line),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

FILE: rtl/ptcf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptcf_checker: port-level checks of the formatter
// Tracks the byte position in the line and checks framing and text layout.
// ----------------------------------------------------------------------------
module ptcf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	logic [ptcf_pkg::CNT_W-1:0] pos_q;
	logic                       out_xfer;

	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_xfer) begin
			if (pos_q == ptcf_pkg::CNT_W'(ptcf_pkg::LINE_BYTES - 1)) pos_q <= '0;
			else pos_q <= pos_q + ptcf_pkg::CNT_W'(1);
		end
	end

	// stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output byte changed under stall");

	// tlast exactly on the twentieth byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (m_tlast == (pos_q == ptcf_pkg::CNT_W'(ptcf_pkg::LINE_BYTES - 1))))
		else $error("tlast out of place");

	// every line opens with the command letter
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && (pos_q == '0) |-> (m_tdata == ptcf_pkg::CH_P))
		else $error("line does not start with P");

	// x coordinate field bytes are decimal digits
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && (pos_q >= ptcf_pkg::CNT_W'(3)) && (pos_q <= ptcf_pkg::CNT_W'(6))
		|-> (m_tdata >= ptcf_pkg::CH_ZERO) && (m_tdata <= ptcf_pkg::CH_NINE))
		else $error("x coordinate byte is not a digit");

endmodule

bind pixel_text_command_formatter_unit ptcf_checker u_ptcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the pixel text command formatter
// Drives pixels and register writes, expects the 20-byte "PX" command line
// of every pixel, typed in or predicted, and checks each output transaction
// byte by byte, under several idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ptcf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int LATENCY_PAD  = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEMS_PER_PH = 50;
	localparam int NUM_PHASES   = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int DEC_CAP      = 9999;    // widest value four digits can print
	localparam int RAND_VAL     = -1;      // phase plan: pick a random offset

	// Register indexes the block does not decode; writes to them are dropped.
	localparam logic [REG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
	localparam logic [REG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

	localparam logic [COORD_W-1:0] COORD_TOP = '1;

	typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} pixel_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [REG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		pixel_t                  px;
	} stim_row_t;

	typedef struct packed {
		char_t ch;
		logic  last;
	} text_byte_t;

	typedef char_t [3:0] quad_t;   // element 0 is the thousands digit

	// DUT ports
	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of the offset registers
	logic [COORD_W-1:0] x_ofs = '0;
	logic [COORD_W-1:0] y_ofs = '0;

	text_byte_t expected_chars[$];   // bytes still owed by the DUT, oldest first
	stim_row_t  stim_rows[$];
	string      stim_text[$];        // typed-in line per row, "" = use predictor

	int char_errors    = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;          // long m_tready hold-off request
	int hold_left      = 0;

	pixel_text_command_formatter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),      // col[11:0], row[11:0], red, green, blue
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),      // out_char[7:0]
		.m_tlast   (m_tlast),      // last
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// Four zero-padded decimal digits; only a 13-bit build could exceed the cap.
	function automatic quad_t dec4_chars(input int v);
		quad_t q;
		int    c;
		c = (v > DEC_CAP) ? DEC_CAP : v;
		q[0] = CH_ZERO + 8'((c / 1000) % 10);
		q[1] = CH_ZERO + 8'((c / 100) % 10);
		q[2] = CH_ZERO + 8'((c / 10) % 10);
		q[3] = CH_ZERO + 8'(c % 10);
		return q;
	endfunction

	function automatic char_t nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_LOW_A + 8'(n) - 8'd10;
	endfunction

	// Whole command line for one pixel under the current offsets.
	function automatic line_t format_px_line(input pixel_t p);
		line_t l;
		quad_t xq;
		quad_t yq;
		xq = dec4_chars(int'(p.col) + int'(x_ofs));
		yq = dec4_chars(int'(p.row) + int'(y_ofs));
		l[0]  = CH_P;
		l[1]  = CH_X;
		l[2]  = CH_SPACE;
		l[7]  = CH_SPACE;
		l[12] = CH_SPACE;
		for (int k = 0; k < 4; k++) begin
			l[3 + k] = xq[k];
			l[8 + k] = yq[k];
		end
		l[13] = nibble_char(p.red[7:4]);
		l[14] = nibble_char(p.red[3:0]);
		l[15] = nibble_char(p.green[7:4]);
		l[16] = nibble_char(p.green[3:0]);
		l[17] = nibble_char(p.blue[7:4]);
		l[18] = nibble_char(p.blue[3:0]);
		l[19] = CH_NL;
		return l;
	endfunction

	function automatic void apply_reg_write(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_X_OFFSET: x_ofs = data;
			REG_Y_OFFSET: y_ofs = data;
			default: ;   // undecoded index, dropped
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus table

	function automatic void add_pixel(input int col, input int row, input int red,
			input int green, input int blue, input string txt);
		stim_row_t r;
		r = '0;
		r.kind     = ROW_PIXEL;
		r.px.col   = COORD_W'(col);
		r.px.row   = COORD_W'(row);
		r.px.red   = 8'(red);
		r.px.green = 8'(green);
		r.px.blue  = 8'(blue);
		stim_rows.push_back(r);
		stim_text.push_back(txt);
	endfunction

	function automatic void add_cfg(input logic [REG_IDX_W-1:0] idx, input int data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.data = CFG_DATA_W'(data);
		stim_rows.push_back(r);
		stim_text.push_back("");
	endfunction

	// Mostly uniform fields, with the odd extreme thrown in for col, row and red.
	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.col   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? COORD_TOP : '0)
		                                   : COORD_W'($urandom);
		p.row   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? COORD_TOP : '0)
		                                   : COORD_W'($urandom);
		p.red   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
		                                   : 8'($urandom);
		p.green = 8'($urandom);
		p.blue  = 8'($urandom);
		return p;
	endfunction

	// ---------------------------------------------------------------- drivers
	// All tasks below are entered and left on a falling edge.

	// One pixel transaction; txt overrides the predictor when not empty.
	task automatic send_pixel(input pixel_t p, input string txt);
		line_t l;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.blue, p.green, p.red, p.row, p.col};
		do @(posedge clk); while (!s_tready);
		l = format_px_line(p);
		for (int k = 0; k < LINE_BYTES; k++) begin
			expected_chars.push_back('{ch: (txt.len() != 0) ? char_t'(txt[k]) : l[k],
			                           last: (k == LINE_BYTES - 1)});
		end
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every owed byte has come, then let the pipeline settle.
	task automatic wait_drain();
		while (expected_chars.size() != 0) @(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	// Idle settings change right after a rising edge so the receiver's
	// falling-edge process sees them without a race.
	task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		hold_req       = hold;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : check_out
		text_byte_t want;
		if (m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				char_errors++;
				if (char_errors <= MAX_REPORTS)
					$display("[%0d] unexpected byte %h last %b", cycle_count, m_tdata, m_tlast);
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata !== want.ch || m_tlast !== want.last) begin
					char_errors++;
					if (char_errors <= MAX_REPORTS)
						$display("[%0d] byte exp %h last %b, got %h last %b",
						         cycle_count, want.ch, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin : stimulus
		int x_plan [NUM_PHASES];
		int y_plan [NUM_PHASES];
		int send_plan [NUM_PHASES];
		int recv_plan [NUM_PHASES];
		int xv;
		int yv;

		// phase plans: offsets at both extremes plus random ones; idle mixes
		x_plan    = '{0, 4095, RAND_VAL, 0, RAND_VAL, 4095};
		y_plan    = '{0, 4095, RAND_VAL, 4095, RAND_VAL, 0};
		send_plan = '{0, 51, 0, 27, 0, 27};
		recv_plan = '{0, 0, 51, 27, 0, 27};

		// directed part: after reset the offsets are zero
		add_pixel(0, 0, 'h00, 'h00, 'h00, "PX 0000 0000 000000\n");
		add_pixel(4095, 4095, 'hff, 'hff, 'hff, "PX 4095 4095 ffffff\n");
		add_pixel(1234, 567, 'h12, 'hab, 'hcd, "PX 1234 0567 12abcd\n");
		add_pixel(9, 10, 'h01, 'h23, 'h45, "");
		add_pixel(2048, 1, 'h67, 'h89, 'hef, "");
		add_pixel('haaa, 'h555, 'haa, 'h55, 'h0f, "");
		// widest sums: both offsets and both coordinates at the top
		add_cfg(REG_X_OFFSET, 4095);
		add_cfg(REG_Y_OFFSET, 4095);
		add_pixel(4095, 4095, 'hff, 'hff, 'hff, "PX 8190 8190 ffffff\n");
		add_pixel(0, 0, 'h00, 'h00, 'h00, "PX 4095 4095 000000\n");
		// undecoded indexes must leave both offsets alone
		add_cfg(IDX_SPARE_A, 0);
		add_cfg(IDX_SPARE_B, 4095);
		add_pixel(5, 4090, 'h80, 'h7f, 'h01, "PX 4100 8185 807f01\n");
		// carry through all four digits
		add_cfg(REG_X_OFFSET, 1);
		add_cfg(REG_Y_OFFSET, 0);
		add_pixel(999, 999, 'h00, 'h00, 'h00, "PX 1000 0999 000000\n");
		add_pixel(8, 99, 'hfe, 'h10, 'h9a, "");
		add_pixel(3998, 4095, 'hc3, 'h3c, 'hb4, "");

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_PIXEL) begin
				send_pixel(stim_rows[i].px, stim_text[i]);
			end else begin
				s_tvalid <= 1'b0;
				wait_drain();
				cfg_write(stim_rows[i].idx, stim_rows[i].data);
			end
		end
		s_tvalid <= 1'b0;

		// random part, one configuration and one idle mix per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drain();
			xv = (x_plan[ph] == RAND_VAL) ? int'($urandom_range(4095)) : x_plan[ph];
			yv = (y_plan[ph] == RAND_VAL) ? int'($urandom_range(4095)) : y_plan[ph];
			if ($urandom_range(1))
				cfg_write($urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B,
				          CFG_DATA_W'($urandom));
			cfg_write(REG_X_OFFSET, CFG_DATA_W'(xv));
			cfg_write(REG_Y_OFFSET, CFG_DATA_W'(yv));
			// first phase: receiver holds off while pixels keep coming, so the
			// conversion stages fill and s_tready drops
			set_idling(send_plan[ph], recv_plan[ph], (ph == 0) ? HOLD_CYCLES : 0);
			for (int n = 0; n < ITEMS_PER_PH; n++) begin
				if (ph == 2 && n == ITEMS_PER_PH / 2) begin
					// sender pauses until the output side is empty
					s_tvalid <= 1'b0;
					wait_drain();
				end
				send_pixel(rand_pixel(), "");
			end
			s_tvalid <= 1'b0;
		end

		wait_drain();
		repeat (LATENCY_PAD) @(posedge clk);
		if (char_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
